// ===== rtl/htw_pkg.sv =====
// htw_pkg: shared types and constants of the Huffman tree table walker.
// Used by htw_node_mem, htw_walk and huffman_tree_table_walker_core.
// No dependencies.
`default_nettype none

package htw_pkg;

	localparam int unsigned NODE_DEPTH = 512;
	localparam int unsigned IDX_W      = 9;
	localparam int unsigned SYM_W      = 9;
	localparam int unsigned WORD_W     = 32;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DECODE = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef struct packed {
		logic leaf;
		idx_t left;
		idx_t right;
	} node_t;

	typedef struct packed {
		op_t               op;
		idx_t              node_slot;
		logic              node_is_leaf;
		idx_t              node_left;
		idx_t              node_right;
		logic              stream_bit;
		logic [WORD_W-1:0] random_word;
	} cmd_t;

	typedef struct packed {
		logic signed [SYM_W-1:0] symbol_value;
		logic                    from_sample;
	} res_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		node_t wdata;
		idx_t  raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC_CUR,
		ST_DEC_NXT,
		ST_SMP_WALK
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/htw_node_mem.sv =====
// htw_node_mem: node table, 512 x 19, one write port, one registered read port.
// Depends on htw_pkg.
`default_nettype none

module htw_node_mem (
	input  wire logic             clk,
	input  wire htw_pkg::mem_req_t req,
	output htw_pkg::node_t         rdata
);

	htw_pkg::node_t mem [htw_pkg::NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/htw_walk.sv =====
// htw_walk: command sequencer; issues table writes and reads, follows child links,
// keeps the decode position and registers the result strobe. Depends on htw_pkg.
`default_nettype none

module htw_walk #(
	parameter int unsigned SYMBOL_BITS = 8,
	parameter int unsigned RANDOM_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire htw_pkg::cmd_t     cmd,
	output logic                   busy,
	input  wire htw_pkg::node_t    rdata,
	output htw_pkg::mem_req_t      mem_req,
	output logic                   result_valid,
	output htw_pkg::res_t          result
);

	localparam int unsigned MAX_WALK = RANDOM_BITS + htw_pkg::NODE_DEPTH;
	localparam int unsigned K_W      = $clog2(MAX_WALK + 1);
	localparam int unsigned RB_USED  = (RANDOM_BITS < htw_pkg::WORD_W) ?
	                                   RANDOM_BITS : htw_pkg::WORD_W;
	localparam int unsigned BIT_W    = $clog2(htw_pkg::WORD_W);
	localparam logic [htw_pkg::SYM_W-1:0] SYM_MASK =
		(SYMBOL_BITS >= htw_pkg::SYM_W) ? {htw_pkg::SYM_W{1'b1}} :
		htw_pkg::SYM_W'((1 << SYMBOL_BITS) - 1);

	htw_pkg::state_t state_q, state_d;
	htw_pkg::idx_t   pos_q, pos_d;
	logic [K_W-1:0]  k_q, k_d;
	logic            stream_bit_q;
	logic [htw_pkg::WORD_W-1:0] word_q;

	logic            accept;
	logic            rbit;
	logic            emit;
	logic            emit_sample;
	logic [htw_pkg::SYM_W-1:0] sym;
	logic [htw_pkg::SYM_W-1:0] emit_val;
	htw_pkg::idx_t   child;

	assign busy   = (state_q != htw_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign sym    = rdata.right & SYM_MASK;
	assign rbit   = (k_q < K_W'(RB_USED)) ? word_q[k_q[BIT_W-1:0]] : 1'b0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htw_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						htw_pkg::OP_DECODE: state_d = htw_pkg::ST_DEC_CUR;
						htw_pkg::OP_SAMPLE: state_d = htw_pkg::ST_SMP_WALK;
						default:            state_d = htw_pkg::ST_IDLE;
					endcase
				end
			end
			htw_pkg::ST_DEC_CUR: begin
				state_d = rdata.leaf ? htw_pkg::ST_IDLE : htw_pkg::ST_DEC_NXT;
			end
			htw_pkg::ST_DEC_NXT: begin
				state_d = htw_pkg::ST_IDLE;
			end
			htw_pkg::ST_SMP_WALK: begin
				if (rdata.leaf || k_q >= K_W'(MAX_WALK)) begin
					state_d = htw_pkg::ST_IDLE;
				end
			end
			default: state_d = htw_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = cmd.node_slot;
		mem_req.wdata = '{leaf: cmd.node_is_leaf, left: cmd.node_left, right: cmd.node_right};
		mem_req.raddr = '0;
		pos_d         = pos_q;
		k_d           = k_q;
		emit          = 1'b0;
		emit_sample   = 1'b0;
		emit_val      = sym;
		child         = '0;
		unique case (state_q)
			htw_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						htw_pkg::OP_LOAD:   mem_req.we = 1'b1;
						htw_pkg::OP_DECODE: mem_req.raddr = pos_q;
						htw_pkg::OP_SAMPLE: begin
							mem_req.raddr = '0;
							k_d           = '0;
						end
						default: ;
					endcase
				end
			end
			htw_pkg::ST_DEC_CUR: begin
				child = stream_bit_q ? rdata.right : rdata.left;
				if (rdata.leaf) begin
					emit  = 1'b1;
					pos_d = '0;
				end else begin
					pos_d         = child;
					mem_req.raddr = child;
				end
			end
			htw_pkg::ST_DEC_NXT: begin
				if (rdata.leaf) begin
					emit  = 1'b1;
					pos_d = '0;
				end
			end
			htw_pkg::ST_SMP_WALK: begin
				child = rbit ? rdata.right : rdata.left;
				if (rdata.leaf) begin
					emit        = 1'b1;
					emit_sample = 1'b1;
					emit_val    = rbit ? (~sym + htw_pkg::SYM_W'(1)) : sym;
				end else if (k_q < K_W'(MAX_WALK)) begin
					mem_req.raddr = child;
					k_d           = k_q + K_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= htw_pkg::ST_IDLE;
			pos_q        <= '0;
			k_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			pos_q        <= pos_d;
			k_q          <= k_d;
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stream_bit_q <= cmd.stream_bit;
			word_q       <= cmd.random_word;
		end
		if (emit) begin
			result.symbol_value <= emit_val;
			result.from_sample  <= emit_sample;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/huffman_tree_table_walker_core.sv =====
// huffman_tree_table_walker_core: top level of the Huffman tree table walker.
// Depends on htw_pkg, htw_node_mem, htw_walk.
//
// Channel   Signals                     Direction  Transaction
// command   start, busy, cmd (cmd_t)    in         start && !busy at a rising edge
// result    result_valid, result(res_t) out        one-cycle strobe, always taken
//
// Steps: a load writes one table entry; a decode reads the current node, then its child
// unless it is a leaf. A sample makes one dependent table read per tree level and
// ends with no result at the step limit when no leaf is found.
// Reset clears the sequencer and the decode position (root); the node table
// holds no reset value and must be loaded before use.
// The receiver cannot stall the registered result strobe; a new command may be taken in it.
`default_nettype none

module huffman_tree_table_walker_core #(
	parameter int unsigned SYMBOL_BITS = 8,
	parameter int unsigned RANDOM_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire htw_pkg::cmd_t  cmd,
	output logic                busy,
	output logic                result_valid,
	output htw_pkg::res_t       result
);

	// memory request and read data between sequencer and node table
	htw_pkg::mem_req_t mem_req;
	htw_pkg::node_t    node_rdata;

	htw_walk #(
		.SYMBOL_BITS (SYMBOL_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.rdata        (node_rdata),
		.mem_req      (mem_req),
		.result_valid (result_valid),
		.result       (result)
	);

	htw_node_mem u_node_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (node_rdata)
	);

endmodule

`default_nettype wire

// ===== tb/sv/htw_checker.sv =====
`timescale 1ns / 1ps
// htw_checker: shadow node table, decode position and result scoreboard for
// huffman_tree_table_walker_core. Depends on htw_pkg only.
module htw_checker #(
	parameter int unsigned SYMBOL_BITS = 8,
	parameter int unsigned RANDOM_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  htw_pkg::cmd_t  cmd,
	input  logic           result_valid,
	input  htw_pkg::res_t  result,
	output int             fail_count,
	output int             outstanding,
	output int             checked_count,
	output int             stalled_walks
);

	localparam int unsigned WALK_LIMIT = RANDOM_BITS + htw_pkg::NODE_DEPTH;

	htw_pkg::node_t shadow_nodes [htw_pkg::NODE_DEPTH];
	htw_pkg::idx_t  decode_pos;
	htw_pkg::res_t  expected_syms [$];
	htw_pkg::res_t  want;

	// bits past the word (or past RANDOM_BITS) read as zero
	function automatic logic word_bit(input logic [31:0] w, input int unsigned k);
		if (k >= RANDOM_BITS || k >= 32)
			return 1'b0;
		return w[k];
	endfunction

	function automatic logic [8:0] leaf_sym(input htw_pkg::node_t n);
		logic [31:0] mask;
		mask = (32'd1 << SYMBOL_BITS) - 32'd1;
		return 9'(32'(n.right) & mask);
	endfunction

	task automatic push_symbol(input logic [8:0] v, input logic smp);
		htw_pkg::res_t r;
		r.symbol_value = v;
		r.from_sample  = smp;
		expected_syms.push_back(r);
	endtask

	task automatic predict_command(input htw_pkg::cmd_t c);
		htw_pkg::node_t cur;
		htw_pkg::idx_t  walk;
		int unsigned    k;
		logic [8:0]     sym;
		logic           found;
		case (c.op)
			htw_pkg::OP_LOAD: begin
				shadow_nodes[c.node_slot].leaf  = c.node_is_leaf;
				shadow_nodes[c.node_slot].left  = c.node_left;
				shadow_nodes[c.node_slot].right = c.node_right;
			end
			htw_pkg::OP_DECODE: begin
				cur = shadow_nodes[decode_pos];
				if (cur.leaf) begin
					// position already on a leaf: emit it, no step taken
					decode_pos = '0;
					push_symbol(leaf_sym(cur), 1'b0);
				end else begin
					decode_pos = c.stream_bit ? cur.right : cur.left;
					if (shadow_nodes[decode_pos].leaf) begin
						push_symbol(leaf_sym(shadow_nodes[decode_pos]), 1'b0);
						decode_pos = '0;
					end
				end
			end
			htw_pkg::OP_SAMPLE: begin
				walk  = '0;
				k     = 0;
				found = 1'b1;
				while (found && !shadow_nodes[walk].leaf) begin
					if (k >= WALK_LIMIT) begin
						found = 1'b0;
					end else begin
						walk = word_bit(c.random_word, k) ? shadow_nodes[walk].right
						                                  : shadow_nodes[walk].left;
						k++;
					end
				end
				if (found) begin
					sym = leaf_sym(shadow_nodes[walk]);
					if (word_bit(c.random_word, k))
						sym = 9'(9'd0 - sym);
					push_symbol(sym, 1'b1);
				end else begin
					stalled_walks++;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_pos = '0;
			expected_syms.delete();
			fail_count    = 0;
			checked_count = 0;
			stalled_walks = 0;
		end else begin
			// retire the result first: a command taken in the strobe cycle queues behind it
			if (result_valid) begin
				if (expected_syms.size() == 0) begin
					$display("%0t: unexpected result symbol %0d from_sample %0b", $time,
						$signed(result.symbol_value), result.from_sample);
					fail_count++;
				end else begin
					want = expected_syms.pop_front();
					checked_count++;
					if (result.symbol_value !== want.symbol_value) begin
						$display("%0t: symbol_value expected %0d actual %0d", $time,
							$signed(want.symbol_value), $signed(result.symbol_value));
						fail_count++;
					end
					if (result.from_sample !== want.from_sample) begin
						$display("%0t: from_sample expected %0b actual %0b", $time,
							want.from_sample, result.from_sample);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_command(cmd);
		end
		outstanding = expected_syms.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset, stimulus and verdict for huffman_tree_table_walker_core.
// Instantiates the block and htw_checker; depends on htw_pkg.
module tb_top;
	import htw_pkg::*;

	localparam int unsigned SYMBOL_BITS = 8;
	localparam int unsigned RANDOM_BITS = 32;
	localparam int RANDOM_ITEMS = 1700;
	// slowest transaction: the longest random gap plus a sample that runs out of steps;
	// several times that with nothing moving is a hang
	localparam int IDLE_LIMIT   = 4000;
	// tail wait covers a step-limited sample that produces no result
	localparam int TAIL_CYCLES  = 600;
	localparam op_t OP_RESERVED = op_t'(2'd3);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic result_valid;
	res_t result;

	int fail_count;
	int outstanding;
	int checked_count;
	int stalled_walks;
	int idle_cycles = 0;

	// stimulus-side bookkeeping: which slots hold a node, so that no walk
	// ever reads an entry that was never loaded
	bit   written [NODE_DEPTH];
	idx_t written_list [$];
	bit   in_tree [NODE_DEPTH];
	idx_t pool [$];

	int n_load = 0;
	int n_decode = 0;
	int n_sample = 0;
	bit no_gaps = 1'b0;

	always #6 clk = ~clk;

	huffman_tree_table_walker_core #(
		.SYMBOL_BITS(SYMBOL_BITS),
		.RANDOM_BITS(RANDOM_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	htw_checker #(
		.SYMBOL_BITS(SYMBOL_BITS),
		.RANDOM_BITS(RANDOM_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked_count(checked_count),
		.stalled_walks(stalled_walks)
	);

	// watchdog: cycles with neither a command transaction nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, %0d cycles without a transaction", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// every field random, so fields an op ignores still toggle
	function automatic cmd_t junk_cmd();
		return cmd_t'(63'({$urandom, $urandom}));
	endfunction

	// drive at the falling edge, hold start until a rising edge sees busy low
	task automatic issue(input cmd_t c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic load_node(input idx_t slot, input logic leaf, input idx_t l, input idx_t r);
		cmd_t c;
		c = junk_cmd();
		c.op           = OP_LOAD;
		c.node_slot    = slot;
		c.node_is_leaf = leaf;
		c.node_left    = l;
		c.node_right   = r;
		issue(c);
		n_load++;
		if (!written[slot]) begin
			written[slot] = 1'b1;
			written_list.push_back(slot);
		end
	endtask

	task automatic decode_bit(input logic b);
		cmd_t c;
		c = junk_cmd();
		c.op         = OP_DECODE;
		c.stream_bit = b;
		issue(c);
		n_decode++;
	endtask

	task automatic sample_word(input logic [31:0] w);
		cmd_t c;
		c = junk_cmd();
		c.op          = OP_SAMPLE;
		c.random_word = w;
		issue(c);
		n_sample++;
	endtask

	task automatic reserved_op();
		cmd_t c;
		c = junk_cmd();
		c.op = OP_RESERVED;
		issue(c);
	endtask

	// stop sending until every expected result is back and the block is idle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
	endtask

	function automatic idx_t pick_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	function automatic idx_t fresh_slot();
		idx_t s;
		s = idx_t'($urandom_range(1, NODE_DEPTH - 1));
		while (in_tree[s]) s = idx_t'($urandom_range(1, NODE_DEPTH - 1));
		in_tree[s] = 1'b1;
		return s;
	endfunction

	task automatic clear_tree_slots();
		for (int i = 0; i < NODE_DEPTH; i++) in_tree[i] = 1'b0;
		in_tree[0] = 1'b1;
	endtask

	// random full binary tree, leaves first, root last at slot 0
	task automatic build_tree(input int leaves);
		idx_t a;
		idx_t b;
		idx_t s;
		int   j;
		clear_tree_slots();
		pool.delete();
		for (int i = 0; i < leaves; i++) begin
			s = fresh_slot();
			load_node(s, 1'b1, idx_t'($urandom), idx_t'($urandom));
			pool.push_back(s);
		end
		while (pool.size() > 1) begin
			j = $urandom_range(0, pool.size() - 1);
			a = pool[j];
			pool.delete(j);
			j = $urandom_range(0, pool.size() - 1);
			b = pool[j];
			pool.delete(j);
			s = (pool.size() == 0) ? idx_t'(0) : fresh_slot();
			load_node(s, 1'b0, a, b);
			pool.push_back(s);
		end
	endtask

	// left-leaning chain deeper than the random word, so walks read the
	// zero bits beyond bit 31
	task automatic build_chain(input int depth);
		idx_t below;
		idx_t leaf_slot;
		idx_t s;
		clear_tree_slots();
		below = fresh_slot();
		load_node(below, 1'b1, idx_t'($urandom), idx_t'($urandom));
		for (int i = depth - 1; i >= 0; i--) begin
			leaf_slot = fresh_slot();
			load_node(leaf_slot, 1'b1, idx_t'($urandom), idx_t'($urandom));
			s = (i == 0) ? idx_t'(0) : fresh_slot();
			load_node(s, 1'b0, below, leaf_slot);
			below = s;
		end
	endtask

	// noise: rewrite any slot; inner nodes only point at loaded slots or
	// themselves, which may close loops that end sample walks at the step limit
	task automatic noise_load();
		idx_t s;
		idx_t l;
		idx_t r;
		s = idx_t'($urandom);
		if ($urandom_range(0, 1)) begin
			load_node(s, 1'b1, idx_t'($urandom), idx_t'($urandom));
		end else begin
			l = ($urandom_range(0, 3) == 0) ? s : pick_written();
			r = ($urandom_range(0, 3) == 0) ? s : pick_written();
			load_node(s, 1'b0, l, r);
		end
	endtask

	task automatic run_burst(input int count, input bit deep);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				decode_bit(1'(($urandom)));
			else if (pick < 90)
				sample_word((deep || $urandom_range(0, 3) == 0) ?
					$urandom >> $urandom_range(0, 31) : $urandom);
			else if (pick < 96)
				noise_load();
			else
				reserved_op();
		end
	endtask

	initial begin
		int  base_items;
		bit  deep;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: root 0 -> left leaf at 1 (symbol 0), right leaf at 511 (symbol 255,
		// bit 8 of the right field set and dropped)
		load_node(9'd511, 1'b1, 9'h1FF, 9'h1FF);
		load_node(9'd1, 1'b1, 9'h000, 9'h000);
		load_node(9'd0, 1'b0, 9'd1, 9'd511);
		decode_bit(1'b0);
		decode_bit(1'b1);
		sample_word(32'h0000_0000);
		sample_word(32'hFFFF_FFFF);
		sample_word(32'h0000_0001);
		sample_word(32'h0000_0002);
		reserved_op();
		// self loop under the root: sample runs to the step limit with no result
		load_node(9'd2, 1'b0, 9'd2, 9'd2);
		load_node(9'd0, 1'b0, 9'd2, 9'd2);
		sample_word(32'hFFFF_FFFF);
		decode_bit(1'b1);
		decode_bit(1'b0);
		// position now parked on node 2: reload it as a leaf mid-decode
		load_node(9'd2, 1'b1, 9'h155, 9'h080);
		decode_bit(1'b0);
		// root itself a leaf
		load_node(9'd0, 1'b1, 9'h0AA, 9'h17F);
		decode_bit(1'b1);
		sample_word(32'h0000_0001);
		sample_word(32'h0000_0000);
		load_node(9'd0, 1'b0, 9'd1, 9'd511);
		drain();

		// random phases: rebuild a tree, then a burst of decodes and samples
		base_items = n_load + n_decode + n_sample;
		while (n_load + n_decode + n_sample - base_items < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			deep    = ($urandom_range(0, 7) == 0);
			if (deep)
				build_chain($urandom_range(33, 40));
			else
				build_tree($urandom_range(2, 16));
			run_burst($urandom_range(30, 80), deep);
			if ($urandom_range(0, 2) == 0)
				drain();
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d node loads, %0d decode bits, %0d sample words", n_load, n_decode,
			n_sample);
		$display("Checked %0d results; %0d sample walks ended at the step limit",
			checked_count, stalled_walks);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
